// ----- rtl/core/fwsa_pkg.sv -----
// Shared types and constants for the four wheel steering angle block.
// Used by the divider cell, the CORDIC cell and the top level; no dependencies.
package fwsa_pkg;

  localparam int SPEED_W = 16;               // magnitude of speed / turn rate
  localparam int NUM_W   = 42;               // |v| * radius constant
  localparam int CW      = 45;               // CORDIC x/y datapath
  localparam int ACC_W   = 32;               // angle accumulator
  localparam int REG_W   = 12;
  localparam int ANG_W   = 15;
  localparam logic [25:0] RADIUS_K = 26'd37549362;
  localparam logic [13:0] ANGLE_MAX = 14'd9000;

  localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;

  // One cell of the long divider: running remainder, numerator/quotient word.
  typedef struct packed {
    logic [SPEED_W-1:0] aw;
    logic [SPEED_W-1:0] rem;
    logic [NUM_W-1:0]   nq;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ACC_W-1:0] acc;
  } cord_t;

  // Per-word control carried beside the datapath.
  typedef struct packed {
    logic valid;
    logic zero_w;
    logic opp;
    logic zp;
    logic np;
    logic zq;
    logic nq;
  } side_t;

  // round(atan(2^-i) * 18000/pi * 2^16)
  function automatic logic signed [ACC_W-1:0] atan_const(input int i);
    logic signed [ACC_W-1:0] t;
    case (i)
      0: t = 32'sd294912000;  1: t = 32'sd174096719;  2: t = 32'sd91987925;
      3: t = 32'sd46694507;   4: t = 32'sd23437865;   5: t = 32'sd11730358;
      6: t = 32'sd5866610;    7: t = 32'sd2933484;    8: t = 32'sd1466764;
      9: t = 32'sd733385;     10: t = 32'sd366693;    11: t = 32'sd183346;
      12: t = 32'sd91673;     13: t = 32'sd45837;     14: t = 32'sd22918;
      15: t = 32'sd11459;     16: t = 32'sd5730;      17: t = 32'sd2865;
      18: t = 32'sd1432;      19: t = 32'sd716;       20: t = 32'sd358;
      21: t = 32'sd179;       22: t = 32'sd90;        23: t = 32'sd45;
      24: t = 32'sd22;        25: t = 32'sd11;        26: t = 32'sd6;
      27: t = 32'sd3;         28: t = 32'sd1;         29: t = 32'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/fwsa_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit per cycle while en is high.
// Depends on fwsa_pkg.
module fwsa_div_cell import fwsa_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t a,
  output div_t b
);

  logic [SPEED_W:0] trial;
  logic             ge;
  div_t             b_next;

  always_comb begin
    trial = {a.rem, a.nq[NUM_W-1]};
    ge    = trial >= {1'b0, a.aw};
    b_next.aw  = a.aw;
    b_next.rem = ge ? SPEED_W'(trial - {1'b0, a.aw}) : trial[SPEED_W-1:0];
    b_next.nq  = {a.nq[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b <= b_next;
    end
  end

endmodule

// ----- rtl/core/fwsa_cordic_cell.sv -----
// One CORDIC vectoring cell: rotates toward y = 0 by atan(2^-STEP).
// Depends on fwsa_pkg.
module fwsa_cordic_cell import fwsa_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t a,
  output cord_t b
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  cord_t                b_next;

  always_comb begin
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    if (!a.y[CW-1]) begin
      b_next.x   = a.x + dx;
      b_next.y   = a.y - dy;
      b_next.acc = a.acc + atan_const(STEP);
    end else begin
      b_next.x   = a.x - dx;
      b_next.y   = a.y + dy;
      b_next.acc = a.acc - atan_const(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b <= b_next;
    end
  end

endmodule

// ----- rtl/core/four_wheel_steering_angles.sv -----
// Four wheel steering angles: top level.
// Depends on fwsa_pkg, fwsa_div_cell, fwsa_cordic_cell.
//
// Takes one word per cycle (speed cm/s, turn rate deg/s) and returns four
// wheel steering angles in 0.01 degree. The turning radius |v|/|w| (mm, Q.16)
// comes out of a row of 42 divider cells, one quotient bit each; two rows of
// ANGLE_ITERATIONS CORDIC cells then find atan(half_length / (r -+ half_width))
// side by side. While s_tready is high every cell hands its word to the next each
// cycle, so a word is accepted every cycle; each result leaves the output register
// after the last CORDIC cell. A zero turn rate gives all zeros. A result that
// the sink does not take is held in the output register and one more in a skid
// register; only when both are full does s_tready drop and the row freeze.
// Registers: index 0 half_length_mm, index 1 half_width_mm (reset 250 / 200);
// other indexes are dropped. Write them only while the block is empty.
module four_wheel_steering_angles import fwsa_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // advance_speed[15:0], turn_rate[31:16]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [63:0]      m_tdata,   // front_left[14:0], front_right[29:15],
                                      // rear_right[44:30], rear_left[59:45]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int N = ANGLE_ITERATIONS;

  logic [REG_W-1:0] half_length;
  logic [REG_W-1:0] half_width;

  // Configuration: always ready, drop unknown indexes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= 12'd250;
      half_width  <= 12'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_LENGTH: half_length <= cfg_data;
        REG_HALF_WIDTH:  half_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole row unless the skid register is holding a word.
  logic adv;
  logic skid_valid;
  assign adv      = !skid_valid;
  assign s_tready = adv;

  // Input stage: |v| times the radius constant, sign flags.
  logic signed [SPEED_W-1:0] v_in;
  logic signed [SPEED_W-1:0] w_in;
  logic [SPEED_W-1:0]        av;
  logic [SPEED_W-1:0]        aw;
  div_t                      div_q [0:NUM_W];
  side_t                     dside [0:NUM_W];
  side_t                     side_in;

  always_comb begin
    v_in = s_tdata[15:0];
    w_in = s_tdata[31:16];
    av   = v_in[SPEED_W-1] ? SPEED_W'(-v_in) : v_in;
    aw   = w_in[SPEED_W-1] ? SPEED_W'(-w_in) : w_in;
    side_in        = '0;
    side_in.valid  = s_tvalid;
    side_in.zero_w = (w_in == '0);
    side_in.opp    = (v_in != '0) && (w_in != '0) && (v_in[SPEED_W-1] ^ w_in[SPEED_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dside[0].valid <= 1'b0;
    end else if (adv) begin
      dside[0].valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0].zero_w <= side_in.zero_w;
      dside[0].opp    <= side_in.opp;
      dside[0].zp     <= 1'b0;
      dside[0].np     <= 1'b0;
      dside[0].zq     <= 1'b0;
      dside[0].nq     <= 1'b0;
      div_q[0].aw     <= aw;
      div_q[0].rem    <= '0;
      div_q[0].nq     <= NUM_W'(av) * NUM_W'(RADIUS_K);
    end
  end

  // Divider row.
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    fwsa_div_cell u_cell (
      .clk (clk),
      .en  (adv),
      .a   (div_q[k]),
      .b   (div_q[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dside[k+1].valid <= 1'b0;
      end else if (adv) begin
        dside[k+1].valid <= dside[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dside[k+1].zero_w <= dside[k].zero_w;
        dside[k+1].opp    <= dside[k].opp;
        dside[k+1].zp     <= dside[k].zp;
        dside[k+1].np     <= dside[k].np;
        dside[k+1].zq     <= dside[k].zq;
        dside[k+1].nq     <= dside[k].nq;
      end
    end
  end

  // Lateral distances r - hw and r + hw, split into magnitude and sign.
  logic signed [NUM_W:0] dp;
  logic signed [NUM_W:0] dq;
  logic signed [NUM_W:0] hw_q16;
  logic signed [NUM_W:0] ap;
  logic signed [NUM_W:0] aq;
  cord_t                 cp [0:N];
  cord_t                 cq [0:N];
  side_t                 cside [0:N];

  always_comb begin
    hw_q16 = (NUM_W+1)'({half_width, 16'b0});
    dp = $signed({1'b0, div_q[NUM_W].nq}) - hw_q16;
    dq = $signed({1'b0, div_q[NUM_W].nq}) + hw_q16;
    ap = dp[NUM_W] ? -dp : dp;
    aq = dq[NUM_W] ? -dq : dq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cside[0].valid <= 1'b0;
    end else if (adv) begin
      cside[0].valid <= dside[NUM_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cside[0].zero_w <= dside[NUM_W].zero_w;
      cside[0].opp    <= dside[NUM_W].opp;
      cside[0].zp     <= (dp == '0);
      cside[0].np     <= dp[NUM_W];
      cside[0].zq     <= (dq == '0);
      cside[0].nq     <= dq[NUM_W];
      cp[0].x   <= CW'(ap);
      cp[0].y   <= CW'({half_length, 16'b0});
      cp[0].acc <= '0;
      cq[0].x   <= CW'(aq);
      cq[0].y   <= CW'({half_length, 16'b0});
      cq[0].acc <= '0;
    end
  end

  // Two CORDIC rows.
  for (genvar i = 0; i < N; i++) begin : g_cordic
    fwsa_cordic_cell #(.STEP(i)) u_p (
      .clk (clk),
      .en  (adv),
      .a   (cp[i]),
      .b   (cp[i+1])
    );

    fwsa_cordic_cell #(.STEP(i)) u_q (
      .clk (clk),
      .en  (adv),
      .a   (cq[i]),
      .b   (cq[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        cside[i+1].valid <= 1'b0;
      end else if (adv) begin
        cside[i+1].valid <= cside[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cside[i+1].zero_w <= cside[i].zero_w;
        cside[i+1].opp    <= cside[i].opp;
        cside[i+1].zp     <= cside[i].zp;
        cside[i+1].np     <= cside[i].np;
        cside[i+1].zq     <= cside[i].zq;
        cside[i+1].nq     <= cside[i].nq;
      end
    end
  end

  // Round the accumulator to 0.01 degree, clamp, apply the distance sign; a zero distance gives ANGLE_MAX.
  function automatic logic signed [ANG_W-1:0] finish(input logic signed [ACC_W-1:0] acc,
                                                    input logic zero_d,
                                                    input logic neg_d);
    logic signed [ACC_W-1:0] t;
    logic signed [ANG_W-1:0] mag;
    t = (acc + 32'sd32768) >>> 16;
    if (acc[ACC_W-1]) begin
      mag = '0;
    end else if (t > $signed({18'b0, ANGLE_MAX})) begin
      mag = ANG_W'(ANGLE_MAX);
    end else begin
      mag = t[ANG_W-1:0];
    end
    if (zero_d) begin
      return ANG_W'(ANGLE_MAX);
    end
    return neg_d ? -mag : mag;
  endfunction

  logic signed [ANG_W-1:0] ang_p;
  logic signed [ANG_W-1:0] ang_q;
  logic signed [ANG_W-1:0] ang_a;
  logic signed [ANG_W-1:0] ang_d;
  logic [63:0]             word_out;
  logic [63:0]             skid_data;
  side_t                   last;

  always_comb begin
    last  = cside[N];
    ang_p = finish(cp[N].acc, last.zp, last.np);
    ang_q = finish(cq[N].acc, last.zq, last.nq);
    if (last.zero_w) begin
      ang_a = '0;
      ang_d = '0;
    end else if (last.opp) begin
      ang_a = -ang_q;
      ang_d = -ang_p;
    end else begin
      ang_a = ang_p;
      ang_d = ang_q;
    end
    word_out = {4'b0, ang_d, -ang_d, -ang_a, ang_a};
  end

  // Output register plus one skid word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (last.valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid_data;
      end
    end else if (last.valid) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= word_out;
      end else begin
        skid_data <= word_out;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A held skid word always sits behind a valid output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid word without output word");

  // Front pair and rear pair are negations of each other.
  a_front_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[29:15]) == -$signed(m_tdata[14:0])))
    else $error("front angles not opposite");

  a_rear_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[44:30]) == -$signed(m_tdata[59:45])))
    else $error("rear angles not opposite");

  // The front left angle stays within a quarter turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd9000 &&
                  $signed(m_tdata[14:0]) >= -15'sd9000))
    else $error("angle out of range");
`endif

endmodule
